### hdl/cll_pkg.sv
// shared types and constants for the cursor linked list engine
// no dependencies
`default_nettype none

package cll_pkg;

    localparam int DEPTH   = 16;
    localparam int WORD_W  = 32;
    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int MODE_W  = 4;
    localparam int FAULT_W = 2;

    typedef enum logic [MODE_W-1:0] {
        M_CLEAR      = 4'd0,
        M_FRONT      = 4'd1,
        M_BACK       = 4'd2,
        M_PREV       = 4'd3,
        M_NEXT       = 4'd4,
        M_PREPEND    = 4'd5,
        M_APPEND     = 4'd6,
        M_BEFORE     = 4'd7,
        M_AFTER      = 4'd8,
        M_DEL_FRONT  = 4'd9,
        M_DEL_BACK   = 4'd10,
        M_DEL_CURSOR = 4'd11,
        M_SET        = 4'd12,
        M_STATUS     = 4'd13
    } t_mode;

    typedef enum logic [FAULT_W-1:0] {
        F_OK    = 2'd0,
        F_FULL  = 2'd1,
        F_EMPTY = 2'd2
    } t_fault;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LINK,
        S_EXEC,
        S_EXEC2,
        S_RD_HEAD,
        S_RD_TAIL,
        S_RD_CUR,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        RD_LINK,
        RD_HEAD,
        RD_TAIL,
        RD_CUR
    } t_rd_sel;

    typedef struct packed {
        logic    accept;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    exec;
        logic    exec2;
        logic    cap_head;
        logic    cap_tail;
        logic    load_out;
    } t_cmd;

endpackage

`default_nettype wire

### hdl/cll_ctrl.sv
// sequencer for the cursor linked list engine: handshakes and phase commands
// depends on cll_pkg
`default_nettype none

module cll_ctrl (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output cll_pkg::t_cmd     o_cmd
);
    import cll_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_cmd.rd_sel = RD_LINK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_LINK;
                end
            end
            S_LINK: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_LINK;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_EXEC2;
            end
            S_EXEC2: begin
                o_cmd.exec2 = 1'b1;
                n_state     = S_RD_HEAD;
            end
            S_RD_HEAD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_HEAD;
                n_state      = S_RD_TAIL;
            end
            S_RD_TAIL: begin
                o_cmd.cap_head = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = RD_TAIL;
                n_state        = S_RD_CUR;
            end
            S_RD_CUR: begin
                o_cmd.cap_tail = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_sel   = RD_CUR;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### hdl/cll_datapath.sv
// list state, slot memories, free slot search and result registers
// depends on cll_pkg
`default_nettype none

module cll_datapath (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire cll_pkg::t_cmd                i_cmd,
    input  wire logic [cll_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [cll_pkg::WORD_W-1:0]   i_data_word,
    output logic [cll_pkg::CNT_W-1:0]         o_count,
    output logic signed [cll_pkg::CNT_W-1:0]  o_cursor_position,
    output logic [cll_pkg::WORD_W-1:0]        o_head_word,
    output logic [cll_pkg::WORD_W-1:0]        o_tail_word,
    output logic [cll_pkg::WORD_W-1:0]        o_cursor_word,
    output logic [cll_pkg::WORD_W-1:0]        o_removed_word,
    output logic [cll_pkg::FAULT_W-1:0]       o_fault
);
    import cll_pkg::*;

    // slot stores
    logic [WORD_W-1:0] r_val_mem  [DEPTH];
    logic [SLOT_W-1:0] r_prev_mem [DEPTH];
    logic [SLOT_W-1:0] r_next_mem [DEPTH];

    // list control state
    logic [DEPTH-1:0]  r_used, n_used;
    logic [SLOT_W-1:0] r_head, n_head, r_tail, n_tail, r_cur, n_cur;
    logic [CNT_W-1:0]  r_cidx, n_cidx, r_cnt, n_cnt;

    // item and per-item results
    t_mode             r_mode;
    logic [WORD_W-1:0] r_data;
    t_fault            r_fault, n_fault;
    logic [WORD_W-1:0] r_removed, n_removed;
    logic [WORD_W-1:0] r_head_st, r_tail_st;

    // deferred second link write
    logic              r_w2p_en, n_w2p_en, r_w2n_en, n_w2n_en;
    logic [SLOT_W-1:0] r_w2p_a, n_w2p_a, r_w2p_d, n_w2p_d;
    logic [SLOT_W-1:0] r_w2n_a, n_w2n_a, r_w2n_d, n_w2n_d;

    // read port
    logic [SLOT_W-1:0] rd_addr;
    logic [WORD_W-1:0] r_rd_val;
    logic [SLOT_W-1:0] r_rd_prev, r_rd_next;

    // write ports
    logic              val_we, prev_we, next_we;
    logic [SLOT_W-1:0] val_wa, prev_wa, next_wa, prev_wd, next_wd;
    logic [WORD_W-1:0] val_wd;

    // free slot search
    logic              do_pre, do_app, backward, cval, empty, full;
    logic [SLOT_W-1:0] start, cand, free_slot;

    assign cval  = ~r_cidx[CNT_W-1];
    assign empty = (r_cnt == '0);
    assign full  = (r_cnt == CNT_W'(DEPTH));
    assign do_pre = (r_mode == M_PREPEND) || ((r_mode == M_BEFORE) && cval && (r_cur == r_head));
    assign do_app = (r_mode == M_APPEND) || ((r_mode == M_AFTER) && cval && (r_cur == r_tail));
    assign backward = do_pre || (r_mode == M_BEFORE);
    assign start = do_pre ? r_head : (do_app ? r_tail : r_cur);

    // rotated priority encoder, nearest free slot wins
    always_comb begin
        free_slot = '0;
        cand      = '0;
        for (int n = DEPTH; n >= 1; n--) begin
            cand = backward ? start - SLOT_W'(n) : start + SLOT_W'(n);
            if (!r_used[cand]) free_slot = cand;
        end
    end

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_LINK: rd_addr = (r_mode == M_DEL_FRONT) ? r_head :
                               ((r_mode == M_DEL_BACK) ? r_tail : r_cur);
            RD_HEAD: rd_addr = r_head;
            RD_TAIL: rd_addr = r_tail;
            RD_CUR:  rd_addr = r_cur;
            default: rd_addr = r_cur;
        endcase
    end

    always_comb begin
        n_used = r_used; n_head = r_head; n_tail = r_tail; n_cur = r_cur;
        n_cidx = r_cidx; n_cnt = r_cnt;
        n_fault = r_fault; n_removed = r_removed;
        n_w2p_en = 1'b0; n_w2p_a = r_w2p_a; n_w2p_d = r_w2p_d;
        n_w2n_en = 1'b0; n_w2n_a = r_w2n_a; n_w2n_d = r_w2n_d;
        val_we = 1'b0; val_wa = '0; val_wd = r_data;
        prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
        next_we = 1'b0; next_wa = '0; next_wd = '0;
        if (i_cmd.exec) begin
            n_fault   = F_OK;
            n_removed = '0;
            if (do_pre || do_app) begin
                if (empty) begin
                    // first node always lands in slot 0
                    val_we = 1'b1; val_wa = '0;
                    prev_we = 1'b1; prev_wa = '0; prev_wd = '0;
                    next_we = 1'b1; next_wa = '0; next_wd = '0;
                    n_used[0] = 1'b1;
                    n_head = '0; n_tail = '0; n_cnt = CNT_W'(1);
                end else if (full) begin
                    n_fault = F_FULL;
                end else if (do_pre) begin
                    val_we = 1'b1; val_wa = free_slot;
                    prev_we = 1'b1; prev_wa = free_slot; prev_wd = free_slot;
                    next_we = 1'b1; next_wa = free_slot; next_wd = r_head;
                    n_w2p_en = 1'b1; n_w2p_a = r_head; n_w2p_d = free_slot;
                    n_used[free_slot] = 1'b1;
                    n_head = free_slot;
                    n_cnt  = r_cnt + CNT_W'(1);
                    if (cval) n_cidx = r_cidx + CNT_W'(1);
                end else begin
                    val_we = 1'b1; val_wa = free_slot;
                    next_we = 1'b1; next_wa = free_slot; next_wd = free_slot;
                    prev_we = 1'b1; prev_wa = free_slot; prev_wd = r_tail;
                    n_w2n_en = 1'b1; n_w2n_a = r_tail; n_w2n_d = free_slot;
                    n_used[free_slot] = 1'b1;
                    n_tail = free_slot;
                    n_cnt  = r_cnt + CNT_W'(1);
                end
            end else begin
                unique case (r_mode)
                    M_CLEAR: begin
                        n_used = '0; n_head = '0; n_tail = '0; n_cur = '0;
                        n_cidx = '1; n_cnt = '0;
                    end
                    M_FRONT: begin
                        if (empty) n_fault = F_EMPTY;
                        else begin
                            n_cur = r_head; n_cidx = '0;
                        end
                    end
                    M_BACK: begin
                        if (empty) n_fault = F_EMPTY;
                        else begin
                            n_cur = r_tail; n_cidx = r_cnt - CNT_W'(1);
                        end
                    end
                    M_PREV: begin
                        if (!cval) n_fault = F_EMPTY;
                        else if (r_cidx == '0) n_cidx = '1;
                        else begin
                            n_cidx = r_cidx - CNT_W'(1); n_cur = r_rd_prev;
                        end
                    end
                    M_NEXT: begin
                        if (!cval) n_fault = F_EMPTY;
                        else if (r_cidx == r_cnt - CNT_W'(1)) n_cidx = '1;
                        else begin
                            n_cidx = r_cidx + CNT_W'(1); n_cur = r_rd_next;
                        end
                    end
                    M_BEFORE: begin
                        if (!cval) n_fault = F_EMPTY;
                        else if (full) n_fault = F_FULL;
                        else begin
                            val_we = 1'b1; val_wa = free_slot;
                            prev_we = 1'b1; prev_wa = free_slot; prev_wd = r_rd_prev;
                            next_we = 1'b1; next_wa = free_slot; next_wd = r_cur;
                            n_w2n_en = 1'b1; n_w2n_a = r_rd_prev; n_w2n_d = free_slot;
                            n_w2p_en = 1'b1; n_w2p_a = r_cur; n_w2p_d = free_slot;
                            n_used[free_slot] = 1'b1;
                            n_cnt  = r_cnt + CNT_W'(1);
                            n_cidx = r_cidx + CNT_W'(1);
                        end
                    end
                    M_AFTER: begin
                        if (!cval) n_fault = F_EMPTY;
                        else if (full) n_fault = F_FULL;
                        else begin
                            val_we = 1'b1; val_wa = free_slot;
                            prev_we = 1'b1; prev_wa = free_slot; prev_wd = r_cur;
                            next_we = 1'b1; next_wa = free_slot; next_wd = r_rd_next;
                            n_w2p_en = 1'b1; n_w2p_a = r_rd_next; n_w2p_d = free_slot;
                            n_w2n_en = 1'b1; n_w2n_a = r_cur; n_w2n_d = free_slot;
                            n_used[free_slot] = 1'b1;
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                    end
                    M_DEL_FRONT, M_DEL_BACK, M_DEL_CURSOR: begin
                        if ((r_mode == M_DEL_CURSOR) ? !cval : empty) begin
                            n_fault = F_EMPTY;
                        end else begin
                            n_removed = r_rd_val;
                            if (r_cnt == CNT_W'(1)) begin
                                n_used = '0; n_head = '0; n_tail = '0; n_cur = '0;
                                n_cidx = '1; n_cnt = '0;
                            end else if ((r_mode == M_DEL_FRONT) ||
                                         ((r_mode == M_DEL_CURSOR) && (r_cidx == '0))) begin
                                n_used[rd_addr] = 1'b0;
                                n_head = r_rd_next;
                                n_cnt  = r_cnt - CNT_W'(1);
                                if (cval) n_cidx = r_cidx - CNT_W'(1);
                            end else if ((r_mode == M_DEL_BACK) ||
                                         (r_cidx == r_cnt - CNT_W'(1))) begin
                                n_used[rd_addr] = 1'b0;
                                n_tail = r_rd_prev;
                                n_cnt  = r_cnt - CNT_W'(1);
                                if (r_cidx == r_cnt - CNT_W'(1)) n_cidx = '1;
                            end else begin
                                // unlink a middle node
                                next_we = 1'b1; next_wa = r_rd_prev; next_wd = r_rd_next;
                                prev_we = 1'b1; prev_wa = r_rd_next; prev_wd = r_rd_prev;
                                n_used[r_cur] = 1'b0;
                                n_cidx = '1;
                                n_cnt  = r_cnt - CNT_W'(1);
                            end
                        end
                    end
                    M_SET: begin
                        if (!cval) n_fault = F_EMPTY;
                        else begin
                            val_we = 1'b1; val_wa = r_cur;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (i_cmd.exec2) begin
            prev_we = r_w2p_en; prev_wa = r_w2p_a; prev_wd = r_w2p_d;
            next_we = r_w2n_en; next_wa = r_w2n_a; next_wd = r_w2n_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_cur  <= '0;
            r_cidx <= '1;
            r_cnt  <= '0;
            r_w2p_en <= 1'b0;
            r_w2n_en <= 1'b0;
        end else begin
            r_used <= n_used;
            r_head <= n_head;
            r_tail <= n_tail;
            r_cur  <= n_cur;
            r_cidx <= n_cidx;
            r_cnt  <= n_cnt;
            r_w2p_en <= n_w2p_en;
            r_w2n_en <= n_w2n_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= t_mode'(i_mode);
            r_data <= i_data_word;
        end
        r_fault   <= n_fault;
        r_removed <= n_removed;
        r_w2p_a <= n_w2p_a; r_w2p_d <= n_w2p_d;
        r_w2n_a <= n_w2n_a; r_w2n_d <= n_w2n_d;
        if (i_cmd.cap_head) r_head_st <= r_rd_val;
        if (i_cmd.cap_tail) r_tail_st <= r_rd_val;
        if (i_cmd.load_out) begin
            o_count           <= r_cnt;
            o_cursor_position <= r_cidx;
            o_head_word       <= empty ? '0 : r_head_st;
            o_tail_word       <= empty ? '0 : r_tail_st;
            o_cursor_word     <= cval ? r_rd_val : '0;
            o_removed_word    <= r_removed;
            o_fault           <= r_fault;
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (val_we)  r_val_mem[val_wa]   <= val_wd;
        if (prev_we) r_prev_mem[prev_wa] <= prev_wd;
        if (next_we) r_next_mem[next_wa] <= next_wd;
        if (i_cmd.rd_en) begin
            r_rd_val  <= r_val_mem[rd_addr];
            r_rd_prev <= r_prev_mem[rd_addr];
            r_rd_next <= r_next_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hdl/cursor_linked_list_engine.sv
// top level of the cursor linked list engine: sequencer plus datapath
// depends on cll_pkg, cll_ctrl, cll_datapath
`default_nettype none

// A doubly linked list of up to 16 words with a cursor. Each input word
// carries one operation and yields exactly one result word with the count,
// cursor index (-1 when undefined), front, back and cursor values, the
// removed value and a fault code. An item passes through one link read, two
// link write phases (the neighbor update needs a read, then up to two writes
// per link store), three reads of the value store's single read port for the
// front, back and cursor values and the result register load, and only then
// does the engine return to idle and accept the next word. The result register
// holds a finished word while the next item is accepted and worked on; the
// last step waits only if the previous result has not yet been taken. A new
// node in a nonempty list takes the nearest free slot found by a rotated
// priority encoder over the slot used bits.
module cursor_linked_list_engine (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [cll_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [cll_pkg::WORD_W-1:0]   i_data_word,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic [cll_pkg::CNT_W-1:0]         o_count,
    output logic signed [cll_pkg::CNT_W-1:0]  o_cursor_position,
    output logic [cll_pkg::WORD_W-1:0]        o_head_word,
    output logic [cll_pkg::WORD_W-1:0]        o_tail_word,
    output logic [cll_pkg::WORD_W-1:0]        o_cursor_word,
    output logic [cll_pkg::WORD_W-1:0]        o_removed_word,
    output logic [cll_pkg::FAULT_W-1:0]       o_fault
);
    import cll_pkg::*;

    // phase commands from the sequencer
    t_cmd cmd;

    cll_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    // list state, slot stores and result register
    cll_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_mode            (i_mode),
        .i_data_word       (i_data_word),
        .o_count           (o_count),
        .o_cursor_position (o_cursor_position),
        .o_head_word       (o_head_word),
        .o_tail_word       (o_tail_word),
        .o_cursor_word     (o_cursor_word),
        .o_removed_word    (o_removed_word),
        .o_fault           (o_fault)
    );

`ifndef SYNTHESIS
    // the list never holds more words than slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_count <= CNT_W'(DEPTH)))
        else $error("count exceeds store depth");

    // a defined cursor lies inside the list
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_cursor_position[CNT_W-1]) |->
            (o_count != '0 && $unsigned(o_cursor_position) < o_count))
        else $error("cursor outside list");

    // a full fault only happens on a full store
    a_full_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fault == F_FULL) |-> (o_count == CNT_W'(DEPTH)))
        else $error("full fault with free slots");

    // one item at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while busy");
`endif

endmodule

`default_nettype wire
